@@ sv/fta_pkg.sv @@
// Shared types and constants for the fixed-timestep accumulator.
package fta_pkg;

   // Fixed field widths
   localparam int KIND_W     = 2;
   localparam int DELTA_W    = 32;
   localparam int DEN_W      = 32;
   localparam int CAP_W      = 16;
   localparam int COUNT_W    = 16;
   localparam int TICK_W     = 64;
   localparam int TOTAL_W    = 64;
   localparam int DROP_W     = 34;
   localparam int PROD_W     = DEN_W + CAP_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [DEN_W-1:0]   STEP_LENGTH_RST = 32'd16667;
   localparam logic [DEN_W-1:0]   FRAME_LIMIT_RST = 32'd250000;
   localparam logic [CAP_W-1:0]   UPDATE_LIMIT_RST = 16'd8;

   // Event kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_ADVANCE = 2'd0,
      KIND_DISCARD = 2'd1,
      KIND_RESET   = 2'd2,
      KIND_IGNORE  = 2'd3
   } kind_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_LENGTH  = 2'd0,
      CSR_FRAME_LIMIT  = 2'd1,
      CSR_UPDATE_LIMIT = 2'd2
   } csr_index_type;

   // Divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ sv/fta_div.sv @@
// Restoring divider: integer quotient, remainder and fraction bits.
module fta_div #(
   parameter int NUM_W  = 33,
   parameter int FRAC_W = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_W-1:0]           num,
   input  logic [fta_pkg::DEN_W-1:0]  den,
   output fta_pkg::div_stat_type      stat,
   output logic [NUM_W-1:0]           quo,
   output logic [fta_pkg::DEN_W-1:0]  rem,
   output logic [FRAC_W-1:0]          frac
);
   import fta_pkg::*;

   localparam int TOT_W = NUM_W + FRAC_W;
   localparam int CNT_W = $clog2(TOT_W);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] rcap_ff, rcap_in;
   logic [TOT_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   shifted;
   logic             ge;

   // One quotient bit per cycle; numerator shifts in zeros once spent
   always_comb begin
      shifted = {rem_ff, num_ff[NUM_W-1]};
      ge      = (shifted >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      rcap_in = rcap_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         rem_in = ge ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
         q_in   = {q_ff[TOT_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         // remainder of the integer part is captured once all NUM_W numerator bits are used
         if (cnt_ff == CNT_W'(NUM_W)) begin
            rcap_in = rem_ff;
         end
         if (cnt_ff == CNT_W'(TOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      rcap_ff <= rcap_in;
      q_ff    <= q_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = q_ff[TOT_W-1:FRAC_W];
   assign frac      = q_ff[FRAC_W-1:0];
   assign rem       = rcap_ff;

endmodule

@@ sv/fixed_timestep_accumulator.sv @@
// Fixed-timestep accumulator top level: sequencer, state and result register.
// Advance: PREP, DIV, DROP, then FIN; DIV waits for the bit-serial divider to finish.
// A new item is taken only once FIN has issued the result and IDLE is reached.
// Discard, reset, ignore: IDLE goes straight to FIN, which waits while a result stalls.
// Synchronous reset restores register defaults and clears accumulator, ticks, total.
module fixed_timestep_accumulator #(
   parameter int TIME_BITS  = 32,
   parameter int ALPHA_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fta_pkg::KIND_W-1:0]      req_kind,
   input  logic signed [fta_pkg::DELTA_W-1:0] req_frame_delta,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [fta_pkg::TICK_W-1:0]      rsp_first_tick_index,
   output logic [fta_pkg::COUNT_W-1:0]     rsp_update_count,
   output logic [fta_pkg::DELTA_W-1:0]     rsp_accepted_delta,
   output logic [fta_pkg::DROP_W-1:0]      rsp_dropped_time,
   output logic [fta_pkg::TICK_W-1:0]      rsp_completed_ticks,
   output logic [ALPHA_BITS-1:0]           rsp_interpolation_alpha,
   output logic [fta_pkg::TOTAL_W-1:0]     rsp_total_dropped,
   input  logic                            csr_write_en,
   input  logic [fta_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fta_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import fta_pkg::*;

   localparam int SUM_W = ((TIME_BITS > DELTA_W) ? TIME_BITS : DELTA_W) + 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_DROP = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic [DEN_W-1:0] step_ff;
   logic [DEN_W-1:0] flim_ff;
   logic [CAP_W-1:0] ulim_ff;
   logic             csr_hit;

   // Scheduler state
   logic [TIME_BITS-1:0] acc_ff, acc_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;

   // Per-item working registers
   kind_type         kind_ff, kind_in;
   logic [DELTA_W-1:0] accepted_ff, accepted_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0] base_ff, base_in;
   logic [SUM_W-1:0] drop_ff, drop_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TICK_W-1:0]    first_ff, first_in;
   logic [COUNT_W-1:0]   ucount_ff, ucount_in;
   logic [DELTA_W-1:0]   racc_ff, racc_in;
   logic [DROP_W-1:0]    rdrop_ff, rdrop_in;
   logic [TICK_W-1:0]    compl_ff, compl_in;
   logic [ALPHA_BITS-1:0] alpha_ff, alpha_in;
   logic [TOTAL_W-1:0]   rtotal_ff, rtotal_in;

   // Effective limits and input conditioning
   logic [DEN_W-1:0]   step_eff;
   logic [DEN_W-1:0]   lim_eff;
   logic [CAP_W-1:0]   cap_eff;
   logic [DELTA_W-1:0] delta_raw;
   logic [DELTA_W-1:0] delta_pos;
   logic [DELTA_W-1:0] delta_clamped;
   logic               take;
   logic               fin_fire;
   logic               over;
   logic [TOTAL_W:0]   total_sum;
   logic [SUM_W-1:0]   sum_now;

   // Divider
   logic                  div_start;
   div_stat_type          div_stat;
   logic [SUM_W-1:0]      div_quo;
   logic [DEN_W-1:0]      div_rem;
   logic [ALPHA_BITS-1:0] div_frac;

   fta_div #(
      .NUM_W  (SUM_W),
      .FRAC_W (ALPHA_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sum_now),
      .den   (step_eff),
      .stat  (div_stat),
      .quo   (div_quo),
      .rem   (div_rem),
      .frac  (div_frac)
   );

   assign step_eff      = (step_ff == '0) ? DEN_W'(1) : step_ff;
   assign lim_eff       = (flim_ff < step_eff) ? step_eff : flim_ff;
   assign cap_eff       = (ulim_ff == '0) ? CAP_W'(1) : ulim_ff;
   assign delta_raw     = req_frame_delta;
   assign delta_pos     = delta_raw[DELTA_W-1] ? '0 : delta_raw;
   assign delta_clamped = (delta_pos < lim_eff) ? delta_pos : lim_eff;
   assign sum_now       = SUM_W'(acc_ff) + SUM_W'(accepted_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;
   assign fin_fire  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   assign over      = (div_quo > SUM_W'(cap_eff));
   assign total_sum = (TOTAL_W + 1)'(total_ff) + (TOTAL_W + 1)'(drop_ff);

   assign csr_hit = csr_write_en &&
                    ((csr_index == CSR_STEP_LENGTH) || (csr_index == CSR_FRAME_LIMIT) ||
                     (csr_index == CSR_UPDATE_LIMIT));

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      accepted_in  = accepted_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      base_in      = base_ff;
      drop_in      = drop_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      tick_in      = tick_ff;
      total_in     = total_ff;
      first_in     = first_ff;
      ucount_in    = ucount_ff;
      racc_in      = racc_ff;
      rdrop_in     = rdrop_ff;
      compl_in     = compl_ff;
      alpha_in     = alpha_ff;
      rtotal_in    = rtotal_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               kind_in     = kind_type'(req_kind);
               accepted_in = delta_clamped;
               state_in    = (kind_type'(req_kind) == KIND_ADVANCE) ? ST_PREP : ST_FIN;
            end
         end
         ST_PREP: begin
            sum_in    = sum_now;
            prod_in   = PROD_W'(cap_eff) * PROD_W'(step_eff);
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            // time left over beyond the steps granted at the cap (sum minus cap times step length)
            base_in = sum_ff - SUM_W'(prod_ff);
            if (div_stat.done) begin
               state_in = ST_DROP;
            end
         end
         ST_DROP: begin
            count_in = over ? cap_eff : COUNT_W'(div_quo);
            drop_in  = over ? (base_ff - SUM_W'(div_rem)) : '0;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (fin_fire) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               first_in     = tick_ff;
               ucount_in    = '0;
               racc_in      = '0;
               rdrop_in     = '0;
               compl_in     = tick_ff;
               alpha_in     = '0;
               rtotal_in    = total_ff;
               case (kind_ff)
                  KIND_ADVANCE: begin
                     acc_in    = TIME_BITS'(div_rem);
                     tick_in   = tick_ff + TICK_W'(count_ff);
                     total_in  = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                     ucount_in = count_ff;
                     racc_in   = accepted_ff;
                     rdrop_in  = DROP_W'(drop_ff);
                     compl_in  = tick_in;
                     alpha_in  = div_frac;
                     rtotal_in = total_in;
                  end
                  KIND_DISCARD: begin
                     acc_in = '0;
                  end
                  KIND_RESET: begin
                     acc_in    = '0;
                     tick_in   = '0;
                     total_in  = '0;
                     first_in  = '0;
                     compl_in  = '0;
                     rtotal_in = '0;
                  end
                  default: begin
                     acc_in = acc_ff;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state, configuration and scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= STEP_LENGTH_RST;
         flim_ff      <= FRAME_LIMIT_RST;
         ulim_ff      <= UPDATE_LIMIT_RST;
         acc_ff       <= '0;
         tick_ff      <= '0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_hit) begin
            case (csr_index_type'(csr_index))
               CSR_STEP_LENGTH:  step_ff <= csr_write_data;
               CSR_FRAME_LIMIT:  flim_ff <= csr_write_data;
               CSR_UPDATE_LIMIT: ulim_ff <= csr_write_data[CAP_W-1:0];
               default:          step_ff <= step_ff;
            endcase
            // reconfiguration restarts the scheduler
            acc_ff   <= '0;
            tick_ff  <= '0;
            total_ff <= '0;
         end else begin
            acc_ff   <= acc_in;
            tick_ff  <= tick_in;
            total_ff <= total_in;
         end
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      accepted_ff <= accepted_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      base_ff     <= base_in;
      drop_ff     <= drop_in;
      count_ff    <= count_in;
      first_ff    <= first_in;
      ucount_ff   <= ucount_in;
      racc_ff     <= racc_in;
      rdrop_ff    <= rdrop_in;
      compl_ff    <= compl_in;
      alpha_ff    <= alpha_in;
      rtotal_ff   <= rtotal_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_first_tick_index    = first_ff;
   assign rsp_update_count        = ucount_ff;
   assign rsp_accepted_delta      = racc_ff;
   assign rsp_dropped_time        = rdrop_ff;
   assign rsp_completed_ticks     = compl_ff;
   assign rsp_interpolation_alpha = alpha_ff;
   assign rsp_total_dropped       = rtotal_ff;

endmodule

@@ sv/fta_check.sv @@
// Port-level checker for the fixed-timestep accumulator, bound to the top level.
module fta_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [fta_pkg::TICK_W-1:0]  rsp_first_tick_index,
   input logic [fta_pkg::COUNT_W-1:0] rsp_update_count,
   input logic [fta_pkg::DROP_W-1:0]  rsp_dropped_time,
   input logic [fta_pkg::TICK_W-1:0]  rsp_completed_ticks
);
   import fta_pkg::*;

   // A stalled result stays offered and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first_tick_index) &&
                                  $stable(rsp_completed_ticks))
      else $error("result changed or dropped while stalled");

   // Tick count after the frame is the count before plus the updates granted
   a_tick_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_completed_ticks == (rsp_first_tick_index + TICK_W'(rsp_update_count)))
      else $error("completed ticks do not match first index plus update count");

   // Time is only dropped when updates were granted, as when the update cap was reached
   a_drop_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_dropped_time != '0) |-> rsp_update_count != '0)
      else $error("time dropped with no updates granted");

   // One item at a time: ready falls right after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

endmodule

bind fixed_timestep_accumulator fta_check u_fta_check (.*);
